// File: sv/trhn_pkg.sv
// Package for the two-region histogram normaliser.
// Holds the function codes, controller state type and the command/status structs.
package trhn_pkg;

  localparam int FuncW = 2;
  localparam int PixW = 16;
  localparam int IdxW = 8;
  localparam int ProbW = 26;
  localparam int AreaOutW = 24;
  localparam int CountW = 25;
  localparam int MinW = 16;
  localparam int FactW = 24;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [ProbW-1:0] ProbMax = 26'd33554432;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PIX_BIN,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_MEM,
    ST_RD_DIV,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_start;
    logic clear_step;
    logic bin_calc;
    logic mem_read;
    logic pix_write;
    logic div_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic div_done;
  } stat_t;

endpackage

// File: sv/trhn_if.sv
// Valid/ready channel interfaces for the histogram normaliser.
// Depends on trhn_pkg for field widths.
interface trhn_in_if;
  import trhn_pkg::*;
  logic valid;
  logic ready;
  logic [FuncW-1:0] func;
  logic [PixW-1:0] pixel_value;
  logic inside_flag;
  logic in_mask;
  logic [IdxW-1:0] bin_index;
  modport source (output valid, func, pixel_value, inside_flag, in_mask, bin_index,
                  input ready);
  modport sink (input valid, func, pixel_value, inside_flag, in_mask, bin_index,
                output ready);
endinterface

interface trhn_out_if;
  import trhn_pkg::*;
  logic valid;
  logic ready;
  logic [ProbW-1:0] inside_prob;
  logic [ProbW-1:0] outside_prob;
  logic [AreaOutW-1:0] area_in;
  logic [AreaOutW-1:0] area_out;
  modport source (output valid, inside_prob, outside_prob, area_in, area_out, input ready);
  modport sink (input valid, inside_prob, outside_prob, area_in, area_out, output ready);
endinterface

// File: sv/trhn_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module trhn_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: sv/trhn_div.sv
// Radix-2 restoring divider, one quotient bit a cycle.
// Divides a count shifted left by 24 by an area; used twice in parallel.
module trhn_div #(
  parameter int NW = 49,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int CntW = $clog2(NW + 1);
  logic [NW-1:0] n_sh;
  logic [DW:0] rem;
  logic [DW-1:0] d;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [DW:0] trial;
  logic [DW:0] diff;

  always_comb begin
    trial = {rem[DW-1:0], n_sh[NW-1]};
    diff = trial - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(NW);
        rem <= '0;
        n_sh <= num;
        d <= den;
        quo <= '0;
      end else if (busy) begin
        n_sh <= {n_sh[NW-2:0], 1'b0};
        if (!diff[DW]) begin
          rem <= diff;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sv/trhn_ctrl.sv
// Controller state machine of the histogram normaliser.
// Depends on trhn_pkg; drives commands into trhn_dp.
module trhn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  input  logic             out_ready,
  input  trhn_pkg::stat_t  stat,
  output trhn_pkg::cmd_t   cmd,
  output logic             in_ready,
  output logic             out_valid
);
  import trhn_pkg::*;
  state_t state, state_next;
  func_t f;
  assign f = func_t'(in_func);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (f)
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_PIXEL: state_next = ST_PIX_BIN;
            FUNC_READ:  state_next = ST_RD_MEM;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:   if (stat.clear_done) state_next = ST_IDLE;
      ST_PIX_BIN: state_next = ST_PIX_RD;
      ST_PIX_RD:  state_next = ST_PIX_WR;
      ST_PIX_WR:  state_next = ST_IDLE;
      ST_RD_MEM:  state_next = ST_RD_DIV;
      ST_RD_DIV:  if (stat.div_done) state_next = ST_OUT;
      ST_OUT:     if (out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
        cmd.clear_start = in_valid && (f == FUNC_CLEAR);
      end
      ST_CLEAR:   cmd.clear_step = 1'b1;
      ST_PIX_BIN: cmd.bin_calc = 1'b1;
      ST_PIX_RD:  cmd.mem_read = 1'b1;
      ST_PIX_WR:  cmd.pix_write = 1'b1;
      ST_RD_MEM:  cmd.mem_read = 1'b1;
      ST_RD_DIV:  begin
        cmd.div_start = 1'b0;
        cmd.out_load = stat.div_done;
      end
      ST_OUT:     out_valid = 1'b1;
      default:    ;
    endcase
    // divider start requested with the RAM read; datapath registers it so that it meets the read data
    if (state == ST_RD_MEM) cmd.div_start = 1'b1;
  end
endmodule

// File: sv/trhn_dp.sv
// Datapath: histogram RAMs, area counters, bin mapping and dividers.
// Depends on trhn_pkg, trhn_ram and trhn_div.
module trhn_dp #(
  parameter int BIN_COUNT = 256,
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  trhn_pkg::cmd_t                   cmd,
  output trhn_pkg::stat_t                  stat,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [trhn_pkg::FactW-1:0]       cfg_data,
  input  logic [trhn_pkg::PixW-1:0]        pixel_value,
  input  logic                             inside_flag,
  input  logic                             in_mask,
  input  logic [trhn_pkg::IdxW-1:0]        bin_index,
  input  logic [1:0]                       func,
  output logic [trhn_pkg::ProbW-1:0]       inside_prob,
  output logic [trhn_pkg::ProbW-1:0]       outside_prob,
  output logic [trhn_pkg::AreaOutW-1:0]    area_in,
  output logic [trhn_pkg::AreaOutW-1:0]    area_out
);
  import trhn_pkg::*;
  localparam int AW = $clog2(BIN_COUNT);
  localparam int ArW = MAX_PIXELS_LOG2;
  localparam int NW = CountW + 24;
  localparam logic [ArW-1:0] AreaLim = {ArW{1'b1}};

  logic [MinW-1:0] range_min;
  logic [FactW-1:0] bin_factor;
  logic [PixW-1:0] pix;
  func_t fn;
  logic pix_in, masked;
  logic [IdxW-1:0] idx;
  logic [AW-1:0] bin, addr, clr_addr;
  logic [ArW-1:0] area_i, area_o;
  logic [CountW-1:0] rd_i, rd_o, wd_i, wd_o;
  logic we_i, we_o, idx_ok;
  logic [PixW:0] diff;
  logic [PixW+FactW-1:0] prod, prod_c;
  logic [PixW+FactW-17:0] bin_full;
  logic [NW-1:0] q_i, q_o;
  logic dn_i, dn_o;
  logic div_go;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= '0;
      bin_factor <= 24'd65536;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) range_min <= cfg_data[MinW-1:0];
      else bin_factor <= cfg_data;
    end
  end

  // item capture; for a pixel item the product is registered in the cycle after capture
  assign diff = {1'b0, pix} - {1'b0, range_min};
  assign prod_c = diff[PixW] ? '0 : diff[PixW-1:0] * bin_factor;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fn <= func_t'(func);
      pix <= pixel_value;
      pix_in <= inside_flag;
      masked <= in_mask;
      idx <= bin_index;
    end
    if (cmd.bin_calc) prod <= prod_c;
  end

  // bin selection, clamped into the last bin
  assign bin_full = prod[PixW+FactW-1:16];
  assign bin = (bin_full >= (PixW+FactW-16)'(BIN_COUNT)) ? AW'(BIN_COUNT - 1)
                                                         : bin_full[AW-1:0];

  // index check against the bin count
  assign idx_ok = ({1'b0, idx} < (IdxW+1)'(BIN_COUNT)) || (AW > IdxW);

  // address: clear sweep, pixel bin or read index
  always_comb begin
    if (cmd.clear_step) addr = clr_addr;
    else if (cmd.pix_write || (cmd.mem_read && fn == FUNC_PIXEL)) addr = bin;
    else addr = AW'(idx);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_start || rst) clr_addr <= '0;
    else if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
  end
  assign stat.clear_done = cmd.clear_step && (clr_addr == AW'(BIN_COUNT - 1));

  // bin update
  always_comb begin
    we_i = cmd.clear_step;
    we_o = cmd.clear_step;
    wd_i = CountW'(1);
    wd_o = CountW'(1);
    if (cmd.pix_write) begin
      we_i = masked && pix_in && (area_i != AreaLim);
      we_o = masked && !pix_in && (area_o != AreaLim);
      wd_i = (rd_i == CountMax) ? rd_i : rd_i + 1'b1;
      wd_o = (rd_o == CountMax) ? rd_o : rd_o + 1'b1;
    end
  end

  trhn_ram #(.WIDTH(CountW), .DEPTH(BIN_COUNT)) u_ram_in (
    .clk(clk), .we(we_i), .addr(addr), .wdata(wd_i), .rdata(rd_i));
  trhn_ram #(.WIDTH(CountW), .DEPTH(BIN_COUNT)) u_ram_out (
    .clk(clk), .we(we_o), .addr(addr), .wdata(wd_o), .rdata(rd_o));

  // area counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      area_i <= '0;
      area_o <= '0;
    end else if (cmd.pix_write) begin
      if (we_i) area_i <= area_i + 1'b1;
      if (we_o) area_o <= area_o + 1'b1;
    end
  end

  // divider start is registered so that it meets the registered RAM read
  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else div_go <= cmd.div_start;
  end

  // normalisation
  trhn_div #(.NW(NW), .DW(ArW)) u_div_in (
    .clk(clk), .rst(rst), .start(div_go), .num({rd_i, 24'd0}),
    .den(area_i == '0 ? ArW'(1) : area_i), .quo(q_i), .done(dn_i));
  trhn_div #(.NW(NW), .DW(ArW)) u_div_out (
    .clk(clk), .rst(rst), .start(div_go), .num({rd_o, 24'd0}),
    .den(area_o == '0 ? ArW'(1) : area_o), .quo(q_o), .done(dn_o));
  assign stat.div_done = dn_i & dn_o;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!idx_ok) inside_prob <= '0;
      else inside_prob <= (q_i > NW'(ProbMax)) ? ProbMax : q_i[ProbW-1:0];
      if (!idx_ok) outside_prob <= '0;
      else outside_prob <= (q_o > NW'(ProbMax)) ? ProbMax : q_o[ProbW-1:0];
      area_in <= AreaOutW'(area_i);
      area_out <= AreaOutW'(area_o);
    end
  end
endmodule

// File: sv/two_region_histogram_normalizer_top.sv
// Two-region histogram normaliser, top level.
// Depends on trhn_pkg, trhn_if, trhn_ctrl, trhn_dp.
//
// One input channel takes items: clear, pixel accumulate or bin read (code 3 is taken and dropped).
// One output channel gives a result beat per read item only.
// The configuration port writes range_min (index 0) and bin_factor (index 1).
// Items are handled one at a time by the controller:
//   pixel: capture, multiply, RAM read, RAM write back, in that order.
//   read: RAM read, then the bit-serial dividers (49 quotient bits), then
//   the result beat, which waits out any output stall.
//   clear: one RAM row per cycle over all BIN_COUNT rows.
// After reset a clearing pass seeds every bin to one;
// no item is accepted during it.
// A result beat stays on the output until taken; while it waits no new
// item is accepted.
module two_region_histogram_normalizer_top #(
  parameter int BIN_COUNT = 256,
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input logic clk,
  input logic rst,
  trhn_in_if.sink in_ch,
  trhn_out_if.source out_ch,
  input logic cfg_we,
  input logic cfg_index,
  input logic [23:0] cfg_data
);
  import trhn_pkg::*;
  cmd_t cmd;
  stat_t stat;

  trhn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_func(in_ch.func),
    .out_ready(out_ch.ready), .stat(stat), .cmd(cmd), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid));

  trhn_dp #(.BIN_COUNT(BIN_COUNT), .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .pixel_value(in_ch.pixel_value),
    .inside_flag(in_ch.inside_flag), .in_mask(in_ch.in_mask),
    .bin_index(in_ch.bin_index), .func(in_ch.func),
    .inside_prob(out_ch.inside_prob), .outside_prob(out_ch.outside_prob),
    .area_in(out_ch.area_in), .area_out(out_ch.area_out));

  // no input taken while a result waits
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
  // probabilities never exceed 2.0 (ProbMax at the 2^24 scale)
  a_prob_sat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.inside_prob <= ProbMax && out_ch.outside_prob <= ProbMax))
    else $error("probability over limit");
  // held inside_prob stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.inside_prob))
    else $error("result changed under stall");
endmodule

// File: test/trhn_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side view of the histogram normaliser channels.
// Holds no logic of its own; the channel interfaces come from sv/trhn_if.sv.
// Depends on trhn_pkg.
package trhn_tb_pkg;
  import trhn_pkg::*;

  // one input beat as the driver holds it
  typedef struct packed {
    func_t            func;
    logic [PixW-1:0]  pixel_value;
    logic             inside_flag;
    logic             in_mask;
    logic [IdxW-1:0]  bin_index;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [ProbW-1:0]    inside_prob;
    logic [ProbW-1:0]    outside_prob;
    logic [AreaOutW-1:0] area_in;
    logic [AreaOutW-1:0] area_out;
  } result_t;

  localparam logic CFG_RANGE_MIN  = 1'b0;
  localparam logic CFG_BIN_FACTOR = 1'b1;
endpackage

// File: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for two_region_histogram_normalizer_top: directed and random items,
// predicted by a behavioural histogram model and checked beat by beat.
// Depends on trhn_pkg, trhn_if and trhn_tb_pkg.
module testbench;
  import trhn_pkg::*;
  import trhn_tb_pkg::*;

  localparam int NBINS = 256;
  localparam int AREA_LIM = (1 << 24) - 1;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [23:0] cfg_data;

  trhn_in_if in_ch ();
  trhn_out_if out_ch ();

  two_region_histogram_normalizer_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // histogram model state
  logic [MinW-1:0]   mdl_min;
  logic [FactW-1:0]  mdl_factor;
  logic [CountW-1:0] hist_in [NBINS];
  logic [CountW-1:0] hist_out [NBINS];
  int unsigned       area_in_cnt, area_out_cnt;

  item_t   pending_items[$];
  result_t expected_reads[$];

  int unsigned cycle_cnt, mismatch_cnt, beats_sent, reads_seen;
  bit hold_long;
  bit in_taken;
  int unsigned long_hold_left;
  int burst_left, gap_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void seed_hist();
    for (int i = 0; i < NBINS; i++) begin
      hist_in[i] = CountW'(1);
      hist_out[i] = CountW'(1);
    end
    area_in_cnt = 0;
    area_out_cnt = 0;
  endfunction

  function automatic logic [ProbW-1:0] bin_ratio(logic [CountW-1:0] c, int unsigned a);
    longint unsigned d, q;
    d = (a != 0) ? a : 1;
    q = ({39'd0, c} << 24) / d;
    if (q > 64'd33554432) q = 64'd33554432;
    return q[ProbW-1:0];
  endfunction

  // applies one accepted beat to the model
  function automatic void predict_hist(item_t it);
    longint unsigned diff, b;
    result_t r;
    case (it.func)
      FUNC_CLEAR: seed_hist();
      FUNC_PIXEL: begin
        if (it.in_mask) begin
          if (it.pixel_value < mdl_min) b = 0;
          else begin
            diff = it.pixel_value - mdl_min;
            b = (diff * mdl_factor) >> 16;
            if (b >= NBINS) b = NBINS - 1;
          end
          if (it.inside_flag) begin
            if (area_in_cnt < AREA_LIM) begin
              area_in_cnt++;
              if (hist_in[b] != CountMax) hist_in[b]++;
            end
          end else if (area_out_cnt < AREA_LIM) begin
            area_out_cnt++;
            if (hist_out[b] != CountMax) hist_out[b]++;
          end
        end
      end
      FUNC_READ: begin
        r.inside_prob = bin_ratio(hist_in[it.bin_index], area_in_cnt);
        r.outside_prob = bin_ratio(hist_out[it.bin_index], area_out_cnt);
        r.area_in = area_in_cnt[23:0];
        r.area_out = area_out_cnt[23:0];
        expected_reads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic item_t mk_item(func_t f, int pix, int ins, int msk, int idx);
    item_t it;
    it.func = f;
    it.pixel_value = pix[PixW-1:0];
    it.inside_flag = ins[0];
    it.in_mask = msk[0];
    it.bin_index = idx[IdxW-1:0];
    return it;
  endfunction

  function automatic item_t rand_item(int rd_pct);
    int p;
    p = $urandom_range(99);
    if (p < rd_pct)
      return mk_item(FUNC_READ, 0, 0, 0, $urandom_range(255));
    if (p == 99) return mk_item(FUNC_NONE, $urandom, $urandom, $urandom, $urandom);
    if (p == 98) return mk_item(FUNC_CLEAR, 0, 0, 1, 0);
    return mk_item(FUNC_PIXEL, ($urandom_range(3) == 0) ? $urandom_range(65535)
                   : $urandom_range(600), $urandom_range(1),
                   int'($urandom_range(7) != 0), 0);
  endfunction

  // driver: bursts and gaps, beats change at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_taken) beats_sent++;
      if (pending_items.size() != 0 && gap_left == 0) begin
        item_t it;
        it = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= it.func;
        in_ch.pixel_value <= it.pixel_value;
        in_ch.inside_flag <= it.inside_flag;
        in_ch.in_mask <= it.in_mask;
        in_ch.bin_index <= it.bin_index;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(20);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_long && long_hold_left != 0) begin
      long_hold_left--;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= (cycle_cnt[9:8] == 2'd0) ? 1'b1 : ($urandom_range(3) != 0);
  end

  // input beat prediction and output checking at the rising edge
  always @(posedge clk) begin
    in_taken = !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        predict_hist(item_t'({in_ch.func, in_ch.pixel_value, in_ch.inside_flag,
                              in_ch.in_mask, in_ch.bin_index}));
      if (out_ch.valid && out_ch.ready) begin
        reads_seen++;
        if (expected_reads.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result beat at cycle %0d", cycle_cnt);
        end else begin
          result_t e;
          e = expected_reads.pop_front();
          if (out_ch.inside_prob !== e.inside_prob || out_ch.outside_prob !== e.outside_prob
              || out_ch.area_in !== e.area_in || out_ch.area_out !== e.area_out) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp in %h out %h ai %0d ao %0d, got in %h out %h ai %0d ao %0d",
                       e.inside_prob, e.outside_prob, e.area_in, e.area_out,
                       out_ch.inside_prob, out_ch.outside_prob, out_ch.area_in,
                       out_ch.area_out);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_reads.size() != 0)
      @(posedge clk);
    // a trailing clear or pixel may still be busy
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RANGE_MIN) mdl_min = val[15:0];
    else mdl_factor = val;
  endtask

  initial begin
    int mins[5];
    int facts[5];
    cycle_cnt = 0; mismatch_cnt = 0; beats_sent = 0; reads_seen = 0;
    hold_long = 0; long_hold_left = 0; burst_left = 0; gap_left = 0;
    in_ch.valid = 0; in_ch.func = FUNC_CLEAR; in_ch.pixel_value = 0;
    in_ch.inside_flag = 0; in_ch.in_mask = 0; in_ch.bin_index = 0;
    out_ch.ready = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    mdl_min = 0; mdl_factor = 24'd65536;
    seed_hist();
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty areas, extremes, mask off, out-of-range bins, func 3
    pending_items.push_back(mk_item(FUNC_READ, 0, 0, 0, 0));
    pending_items.push_back(mk_item(FUNC_READ, 0, 0, 0, 255));
    pending_items.push_back(mk_item(FUNC_PIXEL, 0, 1, 1, 0));
    pending_items.push_back(mk_item(FUNC_PIXEL, 65535, 1, 1, 0));
    pending_items.push_back(mk_item(FUNC_PIXEL, 65535, 0, 1, 0));
    pending_items.push_back(mk_item(FUNC_PIXEL, 5, 0, 0, 0));
    pending_items.push_back(mk_item(FUNC_PIXEL, 255, 0, 1, 255));
    pending_items.push_back(mk_item(FUNC_PIXEL, 16'haaaa, 1, 1, 0));
    pending_items.push_back(mk_item(FUNC_NONE, 16'h5555, 1, 1, 8'haa));
    pending_items.push_back(mk_item(FUNC_READ, 16'hffff, 1, 1, 255));
    pending_items.push_back(mk_item(FUNC_READ, 0, 0, 0, 0));
    pending_items.push_back(mk_item(FUNC_READ, 0, 0, 0, 8'h55));
    pending_items.push_back(mk_item(FUNC_READ, 0, 0, 0, 8'haa));
    pending_items.push_back(mk_item(FUNC_CLEAR, 16'hffff, 1, 1, 8'hff));
    pending_items.push_back(mk_item(FUNC_READ, 0, 0, 0, 255));
    wait_drained();

    // long receiver hold-off while the sender keeps offering beats
    for (int i = 0; i < 40; i++) pending_items.push_back(rand_item(30));
    long_hold_left = 600;
    hold_long = 1;
    wait_drained();
    hold_long = 0;

    // configuration phases, extremes included
    mins = '{0, 100, 65535, 300, 0};
    facts = '{24'hffffff, 24'd0, 24'd65536, 24'd8192, 24'd65536};
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CFG_RANGE_MIN, 24'(mins[ph]));
      cfg_write(CFG_BIN_FACTOR, 24'(facts[ph]));
      pending_items.push_back(mk_item(FUNC_CLEAR, 0, 0, 0, 0));
      for (int i = 0; i < 380; i++) pending_items.push_back(rand_item(6));
      for (int i = 0; i < 4; i++) pending_items.push_back(mk_item(FUNC_READ, 0, 0, 0, i * 85));
      wait_drained();
    end

    $display("covered %0d input beats and %0d result beats over 5 register settings",
             beats_sent, reads_seen);
    if (mismatch_cnt == 0) $display("Test completed successfully");
    else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
